// ----- sv/fatr_pkg.sv -----
// ----------------------------------------------------------------------------
// fatr_pkg
// Types and constants shared by the framed angle triplet receiver and its
// channel interfaces.
// ----------------------------------------------------------------------------
package fatr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = ANGLE_W;
  localparam int unsigned PAYLOAD_LEN = 6;
  localparam int unsigned CNT_W     = 3;

  localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'hAA;
  localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'hBB;

  typedef logic [BYTE_W-1:0]         byte_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_ARM  = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_A  = 3'd0,
    CFG_HIGH_A = 3'd1,
    CFG_LOW_B  = 3'd2,
    CFG_HIGH_B = 3'd3,
    CFG_LOW_C  = 3'd4,
    CFG_HIGH_C = 3'd5
  } cfg_idx_t;

  localparam angle_t LOW_A_RST  = 16'sd7000;
  localparam angle_t HIGH_A_RST = 16'sd18000;
  localparam angle_t LOW_B_RST  = 16'sd0;
  localparam angle_t HIGH_B_RST = 16'sd4500;
  localparam angle_t LOW_C_RST  = 16'sd1000;
  localparam angle_t HIGH_C_RST = 16'sd13000;

  typedef struct packed {
    angle_t angle_a;
    angle_t angle_b;
    angle_t angle_c;
  } result_t;

endpackage

// ----- sv/fatr_in_if.sv -----
// ----------------------------------------------------------------------------
// fatr_in_if
// Request channel into the receiver: an opcode and a received byte.
// ----------------------------------------------------------------------------
interface fatr_in_if;
  import fatr_pkg::*;

  logic            valid;
  logic            ready;
  logic            opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ----- sv/fatr_out_if.sv -----
// ----------------------------------------------------------------------------
// fatr_out_if
// Result channel out of the receiver: three clamped angles.
// ----------------------------------------------------------------------------
interface fatr_out_if;
  import fatr_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle_a;
  angle_t angle_b;
  angle_t angle_c;

  modport source (output valid, output angle_a, output angle_b, output angle_c,
                  input ready);
  modport sink   (input valid, input angle_a, input angle_b, input angle_c,
                  output ready);
endinterface

// ----- sv/framed_angle_triplet_receiver.sv -----
// A result is registered into the output register when the trailer byte is
// accepted, or into the skid entry if the output is held and not taken.
// Throughput: one request per cycle while the skid entry is empty; a frame
// of eight bytes yields at most one result, held in the output register
// with one skid entry behind it. Reset: synchronous, active low; the
// receiver comes up disarmed and idle with the clamp limits at their default values.
// ----------------------------------------------------------------------------
// framed_angle_triplet_receiver
// Frame parser for a head byte, six payload bytes of three little-endian
// signed angles and a trailer byte; the angles are clamped to per-axis limits.
// ----------------------------------------------------------------------------
module framed_angle_triplet_receiver (
  input  logic                        clk,
  input  logic                        rst_n,
  fatr_in_if.sink                     in_req,
  fatr_out_if.source                  out_res,
  input  logic                        cfg_we,
  input  logic [fatr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fatr_pkg::CFG_W-1:0]  cfg_wdata
);
  import fatr_pkg::*;

  function automatic angle_t clamp_angle(input byte_t lo_b, input byte_t hi_b,
                                         input angle_t lo, input angle_t hi);
    angle_t v;
    v = angle_t'({hi_b, lo_b});
    if (v >= hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  angle_t low_a_r, high_a_r, low_b_r, high_b_r, low_c_r, high_c_r;

  logic              armed_r, armed_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  byte_t             payload_r [PAYLOAD_LEN];

  result_t out_data_r, skid_data_r, res_data;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  logic accept, res_fire, out_take, store_byte;

  assign in_req.ready = !skid_valid_r;
  assign accept       = in_req.valid && in_req.ready;
  assign out_take     = out_valid_r && out_res.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_a_r  <= LOW_A_RST;
      high_a_r <= HIGH_A_RST;
      low_b_r  <= LOW_B_RST;
      high_b_r <= HIGH_B_RST;
      low_c_r  <= LOW_C_RST;
      high_c_r <= HIGH_C_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOW_A:  low_a_r  <= angle_t'(cfg_wdata);
        CFG_HIGH_A: high_a_r <= angle_t'(cfg_wdata);
        CFG_LOW_B:  low_b_r  <= angle_t'(cfg_wdata);
        CFG_HIGH_B: high_b_r <= angle_t'(cfg_wdata);
        CFG_LOW_C:  low_c_r  <= angle_t'(cfg_wdata);
        CFG_HIGH_C: high_c_r <= angle_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Frame parser.
  always_comb begin
    armed_nxt      = armed_r;
    in_frame_nxt   = in_frame_r;
    byte_count_nxt = byte_count_r;
    res_fire       = 1'b0;
    store_byte     = 1'b0;
    if (accept) begin
      case (opcode_t'(in_req.opcode))
        OP_ARM: begin
          armed_nxt = 1'b1;
        end
        OP_BYTE: begin
          if (armed_r) begin
            if (!in_frame_r) begin
              if (in_req.rx_byte == FRAME_HEAD) begin
                in_frame_nxt   = 1'b1;
                byte_count_nxt = '0;
              end
            end else if (byte_count_r < CNT_W'(PAYLOAD_LEN)) begin
              store_byte     = 1'b1;
              byte_count_nxt = byte_count_r + CNT_W'(1);
            end else begin
              // Trailer position: the frame closes whatever the byte is.
              in_frame_nxt   = 1'b0;
              byte_count_nxt = '0;
              if (in_req.rx_byte == FRAME_TAIL) begin
                res_fire  = 1'b1;
                armed_nxt = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_data.angle_a = clamp_angle(payload_r[0], payload_r[1], low_a_r, high_a_r);
  assign res_data.angle_b = clamp_angle(payload_r[2], payload_r[3], low_b_r, high_b_r);
  assign res_data.angle_c = clamp_angle(payload_r[4], payload_r[5], low_c_r, high_c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      in_frame_r   <= 1'b0;
      byte_count_r <= '0;
    end else begin
      armed_r      <= armed_nxt;
      in_frame_r   <= in_frame_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_byte) begin
      payload_r[byte_count_r] <= in_req.rx_byte;
    end
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (res_fire) begin
      if (out_valid_r && !out_take) begin
        skid_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_fire) begin
      if (out_valid_r && !out_take) begin
        skid_data_r <= res_data;
      end else begin
        out_data_r <= res_data;
      end
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.angle_a = out_data_r.angle_a;
  assign out_res.angle_b = out_data_r.angle_b;
  assign out_res.angle_c = out_data_r.angle_c;

endmodule
